/* rtl/dsd_pkg.sv */
// Package for the dielectric scatter direction block.
// Holds field widths, fixed-point constants, register indexes and the sequencer states.
// Used by the channel interfaces and the top level.
package dsd_pkg;

   localparam int DIR_FRAC_BITS = 14;
   localparam int DIR_W = 16;
   localparam int IDX_W = 15;
   localparam int IDX_FRAC = 12;
   localparam int ALB_W = 16;
   localparam int RND_W = 16;
   localparam int WGT_W = 18;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [IDX_W-1:0] IDX_RESET = 15'd6144;
   localparam logic [ALB_W-1:0] ALB_RESET = 16'hFFFF;
   localparam logic [IDX_W-1:0] IDX_ONE = 15'd4096;
   localparam logic [IDX_W-1:0] IDX_MAX = 15'd32767;
   localparam logic [WGT_W-1:0] WGT_MAX = 18'd131072;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REFRACTION_INDEX = 2'd0,
      CSR_ALBEDO_RED = 2'd1,
      CSR_ALBEDO_GREEN = 2'd2,
      CSR_ALBEDO_BLUE = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'd0,
      SEQ_RECIP = 2'd1,
      SEQ_FRONT = 2'd2,
      SEQ_BACK = 2'd3
   } seq_state_type;

endpackage

/* rtl/dsd_req_if.sv */
// Request channel interface: valid, ready and the fields of one ray hit item.
// Depends on dsd_pkg for the field widths.
interface dsd_req_if;
   import dsd_pkg::*;

   logic valid;
   logic ready;
   logic signed [DIR_W-1:0] in_dir_x;
   logic signed [DIR_W-1:0] in_dir_y;
   logic signed [DIR_W-1:0] in_dir_z;
   logic signed [DIR_W-1:0] normal_x;
   logic signed [DIR_W-1:0] normal_y;
   logic signed [DIR_W-1:0] normal_z;
   logic back_face;
   logic [RND_W-1:0] random_value;

   modport source (output valid, in_dir_x, in_dir_y, in_dir_z, normal_x, normal_y,
      normal_z, back_face, random_value, input ready);
   modport sink (input valid, in_dir_x, in_dir_y, in_dir_z, normal_x, normal_y,
      normal_z, back_face, random_value, output ready);
endinterface

/* rtl/dsd_rsp_if.sv */
// Response channel interface: valid, ready and the fields of one scattered ray item.
// Depends on dsd_pkg for the field widths.
interface dsd_rsp_if;
   import dsd_pkg::*;

   logic valid;
   logic ready;
   logic signed [DIR_W-1:0] out_dir_x;
   logic signed [DIR_W-1:0] out_dir_y;
   logic signed [DIR_W-1:0] out_dir_z;
   logic [WGT_W-1:0] weight_red;
   logic [WGT_W-1:0] weight_green;
   logic [WGT_W-1:0] weight_blue;
   logic was_reflected;
   logic total_internal;

   modport source (output valid, out_dir_x, out_dir_y, out_dir_z, weight_red,
      weight_green, weight_blue, was_reflected, total_internal, input ready);
   modport sink (input valid, out_dir_x, out_dir_y, out_dir_z, weight_red,
      weight_green, weight_blue, was_reflected, total_internal, output ready);
endinterface

/* rtl/dielectric_scatter_direction_top.sv */
// Dielectric scatter direction: refraction with Schlick reflectance, fully pipelined.
// Depends on dsd_pkg, dsd_req_if and dsd_rsp_if.
//
// Usage: each item on req_ch is one ray hit on a transparent surface (incident
// direction, normal, back-face flag and a random value). For each item exactly one
// item leaves on rsp_ch with the scattered direction, the path weight per color and
// the reflect and total internal reflection flags, in the order of arrival.
// Both channels complete a transfer when valid and ready are high at a clock edge.
// The pipeline has 35 register stages, and one item can be accepted every cycle while
// the divider is idle and rsp_ch is ready.
// The stages between are the dot product, the cosine, Schlick's power chain, Snell's
// law and a 21-stage square root that produces one root bit per stage.
// The user must write registers on the csr port only while no item is in flight;
// the block does not enforce it. After reset, and after every write of the refraction
// index, a shared bit-serial divider computes the reciprocal index and then both
// reflectance ratios; req_ch.ready stays low until it is done.
// When rsp_ch stalls, items pile up in the empty stages; ready falls only when the
// whole pipeline is full, and no item is lost or repeated.
module dielectric_scatter_direction_top (
   input  logic clock,
   input  logic reset,
   dsd_req_if.sink req_ch,
   dsd_rsp_if.source rsp_ch,
   input  logic csr_write_en,
   input  logic [dsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dsd_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import dsd_pkg::*;

   localparam int SQ_STEPS = 21;

   typedef struct {
      logic signed [15:0] n [3];
      logic reflect;
      logic tir;
      logic signed [15:0] rf [3];
      logic signed [20:0] perp [3];
      logic [41:0] rad;
      logic [22:0] rem;
      logic [20:0] root;
   } sqrt_stage_type;

   function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
      logic signed [15:0] r;
      if (v > 25'sd32767) begin
         r = 16'sd32767;
      end else if (v < -25'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Configuration registers and the divider sequencer
   logic [IDX_W-1:0] idx_ff;
   logic [ALB_W-1:0] alb_ff [3];
   logic [IDX_W-1:0] eta_b_ff, eta_b_in;
   logic [16:0] qf_ff, qf_in, qb_ff, qb_in;
   seq_state_type seq_ff, seq_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [IDX_W-1:0] ph_eta;
   logic [IDX_W-1:0] ph_num;
   logic [15:0] ph_den;
   logic [16:0] dv_t;
   logic dv_ge;
   logic [15:0] dv_rem;
   logic [31:0] dv_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= IDX_RESET;
         for (int i = 0; i < 3; i++) begin
            alb_ff[i] <= ALB_RESET;
         end
      end else if (csr_write_en) begin
         case (csr_reg_type'(csr_index))
            CSR_REFRACTION_INDEX: idx_ff <= csr_write_data[IDX_W-1:0];
            CSR_ALBEDO_RED: alb_ff[0] <= csr_write_data;
            CSR_ALBEDO_GREEN: alb_ff[1] <= csr_write_data;
            CSR_ALBEDO_BLUE: alb_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      ph_eta = (seq_ff == SEQ_BACK) ? eta_b_ff : idx_ff;
      ph_num = (ph_eta > IDX_ONE) ? ph_eta - IDX_ONE : IDX_ONE - ph_eta;
      ph_den = 16'(IDX_ONE) + 16'(ph_eta);
      dv_t = {rem_ff, dvd_ff[31]};
      dv_ge = dv_t >= {1'b0, dvs_ff};
      dv_rem = dv_ge ? 16'(dv_t - {1'b0, dvs_ff}) : dv_t[15:0];
      dv_quo = {dvd_ff[30:0], dv_ge};
      seq_in = seq_ff;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      eta_b_in = eta_b_ff;
      qf_in = qf_ff;
      qb_in = qb_ff;
      case (seq_ff)
         SEQ_IDLE: ;
         SEQ_RECIP, SEQ_FRONT, SEQ_BACK: begin
            if (cnt_ff == 6'd0) begin
               if (seq_ff == SEQ_RECIP) begin
                  dvd_in = 32'h0100_0000 + 32'(idx_ff >> 1);
                  dvs_in = {1'b0, idx_ff};
               end else begin
                  dvd_in = {1'b0, ph_num, 16'h0000} + 32'(ph_den >> 1);
                  dvs_in = ph_den;
               end
               rem_in = 16'd0;
               cnt_in = 6'd1;
            end else begin
               dvd_in = dv_quo;
               rem_in = dv_rem;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd32) begin
                  cnt_in = 6'd0;
                  case (seq_ff)
                     SEQ_RECIP: begin
                        eta_b_in = (dv_quo > 32'(IDX_MAX)) ? IDX_MAX : dv_quo[IDX_W-1:0];
                        seq_in = SEQ_FRONT;
                     end
                     SEQ_FRONT: begin
                        qf_in = dv_quo[16:0];
                        seq_in = SEQ_BACK;
                     end
                     default: begin
                        qb_in = dv_quo[16:0];
                        seq_in = SEQ_IDLE;
                     end
                  endcase
               end
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
      if (csr_write_en && (csr_reg_type'(csr_index) == CSR_REFRACTION_INDEX)) begin
         seq_in = SEQ_RECIP;
         cnt_in = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_RECIP;
         cnt_ff <= 6'd0;
      end else begin
         seq_ff <= seq_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      eta_b_ff <= eta_b_in;
      qf_ff <= qf_in;
      qb_ff <= qb_in;
   end

   // Pipeline enables: a stage moves when it is empty or the next one moves
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic vq_ff [SQ_STEPS+1];
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   logic en1, en2, en3, en4, en5, en6, en7, en8;
   logic enq [SQ_STEPS+1];
   logic en_a, en_b, en_c, en_d, en_e;
   logic req_fire;

   always_comb begin
      en_e = !ve_ff || rsp_ch.ready;
      en_d = !vd_ff || en_e;
      en_c = !vc_ff || en_d;
      en_b = !vb_ff || en_c;
      en_a = !va_ff || en_b;
      enq[SQ_STEPS] = !vq_ff[SQ_STEPS] || en_a;
      for (int k = SQ_STEPS - 1; k >= 0; k--) begin
         enq[k] = !vq_ff[k] || enq[k+1];
      end
      en8 = !v8_ff || enq[0];
      en7 = !v7_ff || en8;
      en6 = !v6_ff || en7;
      en5 = !v5_ff || en6;
      en4 = !v4_ff || en5;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
   end

   assign req_ch.ready = en1 && (seq_ff == SEQ_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         for (int k = 0; k <= SQ_STEPS; k++) begin
            vq_ff[k] <= 1'b0;
         end
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_fire;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
         if (en7) v7_ff <= v6_ff;
         if (en8) v8_ff <= v7_ff;
         if (enq[0]) vq_ff[0] <= v8_ff;
         for (int k = 1; k <= SQ_STEPS; k++) begin
            if (enq[k]) vq_ff[k] <= vq_ff[k-1];
         end
         if (en_a) va_ff <= vq_ff[SQ_STEPS];
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
         if (en_d) vd_ff <= vc_ff;
         if (en_e) ve_ff <= vd_ff;
      end
   end

   // Stage 1: capture, index ratio selection, component products of the dot
   logic signed [15:0] req_d [3];
   logic signed [15:0] req_n [3];
   logic signed [15:0] s1_d_ff [3];
   logic signed [15:0] s1_n_ff [3];
   logic [RND_W-1:0] s1_rnd_ff;
   logic [IDX_W-1:0] s1_eta_ff;
   logic [16:0] s1_q_ff;
   logic signed [31:0] s1_p_ff [3];

   always_comb begin
      req_d[0] = req_ch.in_dir_x;
      req_d[1] = req_ch.in_dir_y;
      req_d[2] = req_ch.in_dir_z;
      req_n[0] = req_ch.normal_x;
      req_n[1] = req_ch.normal_y;
      req_n[2] = req_ch.normal_z;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int i = 0; i < 3; i++) begin
            s1_d_ff[i] <= req_d[i];
            s1_n_ff[i] <= req_n[i];
            s1_p_ff[i] <= req_d[i] * req_n[i];
         end
         s1_rnd_ff <= req_ch.random_value;
         s1_eta_ff <= req_ch.back_face ? eta_b_ff : idx_ff;
         s1_q_ff <= req_ch.back_face ? qb_ff : qf_ff;
      end
   end

   // Stage 2: dot sum, eta squared, r0
   logic signed [15:0] s2_d_ff [3];
   logic signed [15:0] s2_n_ff [3];
   logic [RND_W-1:0] s2_rnd_ff;
   logic [IDX_W-1:0] s2_eta_ff;
   logic signed [33:0] s2_dot_ff, s2_dot_in;
   logic [29:0] s2_eta2_ff, s2_eta2_in;
   logic [16:0] s2_r0_ff, s2_r0_in;
   logic [33:0] s2_qq;

   always_comb begin
      s2_dot_in = s1_p_ff[0] + s1_p_ff[1] + s1_p_ff[2];
      s2_eta2_in = s1_eta_ff * s1_eta_ff;
      s2_qq = s1_q_ff * s1_q_ff;
      s2_r0_in = 17'((s2_qq + 34'd32768) >> 16);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_d_ff <= s1_d_ff;
         s2_n_ff <= s1_n_ff;
         s2_rnd_ff <= s1_rnd_ff;
         s2_eta_ff <= s1_eta_ff;
         s2_dot_ff <= s2_dot_in;
         s2_eta2_ff <= s2_eta2_in;
         s2_r0_ff <= s2_r0_in;
      end
   end

   // Stage 3: cosine, rounded and clamped
   logic signed [15:0] s3_d_ff [3];
   logic signed [15:0] s3_n_ff [3];
   logic [RND_W-1:0] s3_rnd_ff;
   logic [IDX_W-1:0] s3_eta_ff;
   logic signed [33:0] s3_dot_ff;
   logic [29:0] s3_eta2_ff;
   logic [16:0] s3_r0_ff;
   logic signed [15:0] s3_c_ff, s3_c_in;
   logic signed [34:0] s3_negd;
   logic signed [34:0] s3_cr;

   always_comb begin
      s3_negd = -s2_dot_ff;
      s3_cr = (s3_negd + 35'sd8192) >>> DIR_FRAC_BITS;
      if (s3_cr > 35'sd16384) begin
         s3_c_in = 16'sd16384;
      end else if (s3_cr < -35'sd16384) begin
         s3_c_in = -16'sd16384;
      end else begin
         s3_c_in = s3_cr[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_d_ff <= s2_d_ff;
         s3_n_ff <= s2_n_ff;
         s3_rnd_ff <= s2_rnd_ff;
         s3_eta_ff <= s2_eta_ff;
         s3_dot_ff <= s2_dot_ff;
         s3_eta2_ff <= s2_eta2_ff;
         s3_r0_ff <= s2_r0_ff;
         s3_c_ff <= s3_c_in;
      end
   end

   // Stage 4: sin squared, Schlick base, products with the normal
   logic signed [15:0] s4_d_ff [3];
   logic signed [15:0] s4_n_ff [3];
   logic [RND_W-1:0] s4_rnd_ff;
   logic [IDX_W-1:0] s4_eta_ff;
   logic [29:0] s4_eta2_ff;
   logic [16:0] s4_r0_ff;
   logic [14:0] s4_s2_ff, s4_s2_in;
   logic [16:0] s4_m_ff, s4_m_in;
   logic signed [31:0] s4_cn_ff [3];
   logic signed [49:0] s4_dn_ff [3];
   logic signed [31:0] s4_cc;
   logic signed [31:0] s4_ccr;
   logic [14:0] s4_cpos;

   always_comb begin
      s4_cc = s3_c_ff * s3_c_ff;
      s4_ccr = (s4_cc + 32'sd8192) >>> DIR_FRAC_BITS;
      s4_s2_in = 15'd16384 - s4_ccr[14:0];
      s4_cpos = s3_c_ff[15] ? 15'd0 : s3_c_ff[14:0];
      s4_m_in = 17'd65536 - {s4_cpos, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_d_ff <= s3_d_ff;
         s4_n_ff <= s3_n_ff;
         s4_rnd_ff <= s3_rnd_ff;
         s4_eta_ff <= s3_eta_ff;
         s4_eta2_ff <= s3_eta2_ff;
         s4_r0_ff <= s3_r0_ff;
         s4_s2_ff <= s4_s2_in;
         s4_m_ff <= s4_m_in;
         for (int i = 0; i < 3; i++) begin
            s4_cn_ff[i] <= s3_c_ff * s3_n_ff[i];
            s4_dn_ff[i] <= s3_dot_ff * s3_n_ff[i];
         end
      end
   end

   // Stage 5: total internal reflection test, m^2, d + cos*n, mirror direction
   logic signed [15:0] s5_n_ff [3];
   logic [RND_W-1:0] s5_rnd_ff;
   logic [IDX_W-1:0] s5_eta_ff;
   logic [16:0] s5_r0_ff;
   logic [16:0] s5_m_ff;
   logic s5_tir_ff, s5_tir_in;
   logic [16:0] s5_m2_ff, s5_m2_in;
   logic signed [17:0] s5_t_ff [3];
   logic signed [17:0] s5_t_in [3];
   logic signed [15:0] s5_rf_ff [3];
   logic signed [15:0] s5_rf_in [3];
   logic [44:0] s5_te;
   logic [33:0] s5_mm;
   logic signed [31:0] s5_cnr [3];
   logic signed [49:0] s5_dnr [3];
   logic signed [24:0] s5_rfd [3];

   always_comb begin
      s5_te = s4_eta2_ff * s4_s2_ff;
      s5_tir_in = s5_te > 45'h40_0000_0000;
      s5_mm = s4_m_ff * s4_m_ff;
      s5_m2_in = 17'((s5_mm + 34'd32768) >> 16);
      for (int i = 0; i < 3; i++) begin
         s5_cnr[i] = (s4_cn_ff[i] + 32'sd8192) >>> DIR_FRAC_BITS;
         s5_t_in[i] = s4_d_ff[i] + $signed(s5_cnr[i][17:0]);
         s5_dnr[i] = (s4_dn_ff[i] + 50'sd67108864) >>> 27;
         s5_rfd[i] = s4_d_ff[i] - $signed(s5_dnr[i][23:0]);
         s5_rf_in[i] = sat16(s5_rfd[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_n_ff <= s4_n_ff;
         s5_rnd_ff <= s4_rnd_ff;
         s5_eta_ff <= s4_eta_ff;
         s5_r0_ff <= s4_r0_ff;
         s5_m_ff <= s4_m_ff;
         s5_tir_ff <= s5_tir_in;
         s5_m2_ff <= s5_m2_in;
         s5_t_ff <= s5_t_in;
         s5_rf_ff <= s5_rf_in;
      end
   end

   // Stage 6: m^4, perpendicular part scaled by eta
   logic signed [15:0] s6_n_ff [3];
   logic [RND_W-1:0] s6_rnd_ff;
   logic [16:0] s6_r0_ff;
   logic [16:0] s6_m_ff;
   logic s6_tir_ff;
   logic signed [15:0] s6_rf_ff [3];
   logic [16:0] s6_m4_ff, s6_m4_in;
   logic signed [20:0] s6_perp_ff [3];
   logic signed [20:0] s6_perp_in [3];
   logic [33:0] s6_mm;
   logic signed [33:0] s6_te [3];
   logic signed [33:0] s6_pr [3];

   always_comb begin
      s6_mm = s5_m2_ff * s5_m2_ff;
      s6_m4_in = 17'((s6_mm + 34'd32768) >> 16);
      for (int i = 0; i < 3; i++) begin
         s6_te[i] = s5_t_ff[i] * $signed({1'b0, s5_eta_ff});
         s6_pr[i] = (s6_te[i] + 34'sd2048) >>> IDX_FRAC;
         s6_perp_in[i] = s6_pr[i][20:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         s6_n_ff <= s5_n_ff;
         s6_rnd_ff <= s5_rnd_ff;
         s6_r0_ff <= s5_r0_ff;
         s6_m_ff <= s5_m_ff;
         s6_tir_ff <= s5_tir_ff;
         s6_rf_ff <= s5_rf_ff;
         s6_m4_ff <= s6_m4_in;
         s6_perp_ff <= s6_perp_in;
      end
   end

   // Stage 7: m^5, squares of the perpendicular part
   logic signed [15:0] s7_n_ff [3];
   logic [RND_W-1:0] s7_rnd_ff;
   logic [16:0] s7_r0_ff;
   logic s7_tir_ff;
   logic signed [15:0] s7_rf_ff [3];
   logic signed [20:0] s7_perp_ff [3];
   logic [16:0] s7_m5_ff, s7_m5_in;
   logic [40:0] s7_sq_ff [3];
   logic [40:0] s7_sq_in [3];
   logic [33:0] s7_mm;
   logic signed [41:0] s7_sqw [3];

   always_comb begin
      s7_mm = s6_m4_ff * s6_m_ff;
      s7_m5_in = 17'((s7_mm + 34'd32768) >> 16);
      for (int i = 0; i < 3; i++) begin
         s7_sqw[i] = s6_perp_ff[i] * s6_perp_ff[i];
         s7_sq_in[i] = s7_sqw[i][40:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         s7_n_ff <= s6_n_ff;
         s7_rnd_ff <= s6_rnd_ff;
         s7_r0_ff <= s6_r0_ff;
         s7_tir_ff <= s6_tir_ff;
         s7_rf_ff <= s6_rf_ff;
         s7_perp_ff <= s6_perp_ff;
         s7_m5_ff <= s7_m5_in;
         s7_sq_ff <= s7_sq_in;
      end
   end

   // Stage 8: reflectance, square root operand
   logic signed [15:0] s8_n_ff [3];
   logic [RND_W-1:0] s8_rnd_ff;
   logic s8_tir_ff;
   logic signed [15:0] s8_rf_ff [3];
   logic signed [20:0] s8_perp_ff [3];
   logic [17:0] s8_refl_ff, s8_refl_in;
   logic [41:0] s8_rad_ff, s8_rad_in;
   logic [16:0] s8_omr;
   logic [33:0] s8_pr;
   logic [42:0] s8_len2;
   logic signed [43:0] s8_diff;
   logic signed [43:0] s8_adiff;

   always_comb begin
      s8_omr = 17'd65536 - s7_r0_ff;
      s8_pr = s8_omr * s7_m5_ff;
      s8_refl_in = 18'(s7_r0_ff) + 18'((s8_pr + 34'd32768) >> 16);
      s8_len2 = 43'(s7_sq_ff[0]) + 43'(s7_sq_ff[1]) + 43'(s7_sq_ff[2]);
      s8_diff = 44'sd268435456 - $signed({1'b0, s8_len2});
      s8_adiff = s8_diff[43] ? -s8_diff : s8_diff;
      s8_rad_in = s8_adiff[41:0];
   end

   always_ff @(posedge clock) begin
      if (en8) begin
         s8_n_ff <= s7_n_ff;
         s8_rnd_ff <= s7_rnd_ff;
         s8_tir_ff <= s7_tir_ff;
         s8_rf_ff <= s7_rf_ff;
         s8_perp_ff <= s7_perp_ff;
         s8_refl_ff <= s8_refl_in;
         s8_rad_ff <= s8_rad_in;
      end
   end

   // Reflect decision, then the square root, one root bit per stage
   sqrt_stage_type sq_ff [SQ_STEPS+1];
   sqrt_stage_type sq_in [SQ_STEPS+1];
   logic [24:0] sq_rem_sh [SQ_STEPS+1];
   logic [24:0] sq_trial [SQ_STEPS+1];

   always_comb begin
      sq_in[0].n = s8_n_ff;
      sq_in[0].reflect = s8_tir_ff || (s8_refl_ff > 18'(s8_rnd_ff));
      sq_in[0].tir = s8_tir_ff;
      sq_in[0].rf = s8_rf_ff;
      sq_in[0].perp = s8_perp_ff;
      sq_in[0].rad = s8_rad_ff;
      sq_in[0].rem = 23'd0;
      sq_in[0].root = 21'd0;
      sq_rem_sh[0] = 25'd0;
      sq_trial[0] = 25'd0;
      for (int k = 1; k <= SQ_STEPS; k++) begin
         sq_in[k] = sq_ff[k-1];
         sq_rem_sh[k] = {sq_ff[k-1].rem, sq_ff[k-1].rad[41:40]};
         sq_trial[k] = {2'b00, sq_ff[k-1].root, 2'b01};
         sq_in[k].rad = {sq_ff[k-1].rad[39:0], 2'b00};
         if (sq_rem_sh[k] >= sq_trial[k]) begin
            sq_in[k].rem = 23'(sq_rem_sh[k] - sq_trial[k]);
            sq_in[k].root = {sq_ff[k-1].root[19:0], 1'b1};
         end else begin
            sq_in[k].rem = sq_rem_sh[k][22:0];
            sq_in[k].root = {sq_ff[k-1].root[19:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= SQ_STEPS; k++) begin
         if (enq[k]) sq_ff[k] <= sq_in[k];
      end
   end

   // Stage A: parallel part times the normal
   logic signed [15:0] sa_n_ff [3];
   logic sa_reflect_ff, sa_tir_ff;
   logic signed [15:0] sa_rf_ff [3];
   logic signed [20:0] sa_perp_ff [3];
   logic signed [37:0] sa_pn_ff [3];

   always_ff @(posedge clock) begin
      if (en_a) begin
         sa_n_ff <= sq_ff[SQ_STEPS].n;
         sa_reflect_ff <= sq_ff[SQ_STEPS].reflect;
         sa_tir_ff <= sq_ff[SQ_STEPS].tir;
         sa_rf_ff <= sq_ff[SQ_STEPS].rf;
         sa_perp_ff <= sq_ff[SQ_STEPS].perp;
         for (int i = 0; i < 3; i++) begin
            sa_pn_ff[i] <= $signed({1'b0, sq_ff[SQ_STEPS].root}) * sq_ff[SQ_STEPS].n[i];
         end
      end
   end

   // Stage B: refracted direction and final direction select
   logic signed [15:0] sb_n_ff [3];
   logic sb_reflect_ff, sb_tir_ff;
   logic signed [15:0] sb_o_ff [3];
   logic signed [15:0] sb_o_in [3];
   logic signed [37:0] sb_pnr [3];
   logic signed [24:0] sb_od [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sb_pnr[i] = (sa_pn_ff[i] + 38'sd8192) >>> DIR_FRAC_BITS;
         sb_od[i] = sa_perp_ff[i] - $signed(sb_pnr[i][23:0]);
         sb_o_in[i] = sa_reflect_ff ? sa_rf_ff[i] : sat16(sb_od[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         sb_n_ff <= sa_n_ff;
         sb_reflect_ff <= sa_reflect_ff;
         sb_tir_ff <= sa_tir_ff;
         sb_o_ff <= sb_o_in;
      end
   end

   // Stage C: products of the normal and the new direction
   logic sc_reflect_ff, sc_tir_ff;
   logic signed [15:0] sc_o_ff [3];
   logic signed [31:0] sc_wn_ff [3];

   always_ff @(posedge clock) begin
      if (en_c) begin
         sc_reflect_ff <= sb_reflect_ff;
         sc_tir_ff <= sb_tir_ff;
         sc_o_ff <= sb_o_ff;
         for (int i = 0; i < 3; i++) begin
            sc_wn_ff[i] <= sb_n_ff[i] * sb_o_ff[i];
         end
      end
   end

   // Stage D: absolute cosine of the new direction
   logic sd_reflect_ff, sd_tir_ff;
   logic signed [15:0] sd_o_ff [3];
   logic [31:0] sd_aw_ff, sd_aw_in;
   logic signed [33:0] sd_wd;
   logic signed [33:0] sd_awd;

   always_comb begin
      sd_wd = sc_wn_ff[0] + sc_wn_ff[1] + sc_wn_ff[2];
      sd_awd = sd_wd[33] ? -sd_wd : sd_wd;
      sd_aw_in = sd_awd[31:0];
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         sd_reflect_ff <= sc_reflect_ff;
         sd_tir_ff <= sc_tir_ff;
         sd_o_ff <= sc_o_ff;
         sd_aw_ff <= sd_aw_in;
      end
   end

   // Stage E: weights per color, output register
   logic se_reflect_ff, se_tir_ff;
   logic signed [15:0] se_o_ff [3];
   logic [WGT_W-1:0] se_w_ff [3];
   logic [WGT_W-1:0] se_w_in [3];
   logic [47:0] se_pw [3];
   logic [20:0] se_wr [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         se_pw[i] = sd_aw_ff * alb_ff[i];
         se_wr[i] = 21'((se_pw[i] + 48'd67108864) >> 27);
         se_w_in[i] = (se_wr[i] > 21'(WGT_MAX)) ? WGT_MAX : se_wr[i][WGT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         se_reflect_ff <= sd_reflect_ff;
         se_tir_ff <= sd_tir_ff;
         se_o_ff <= sd_o_ff;
         se_w_ff <= se_w_in;
      end
   end

   assign rsp_ch.valid = ve_ff;
   assign rsp_ch.out_dir_x = se_o_ff[0];
   assign rsp_ch.out_dir_y = se_o_ff[1];
   assign rsp_ch.out_dir_z = se_o_ff[2];
   assign rsp_ch.weight_red = se_w_ff[0];
   assign rsp_ch.weight_green = se_w_ff[1];
   assign rsp_ch.weight_blue = se_w_ff[2];
   assign rsp_ch.was_reflected = se_reflect_ff;
   assign rsp_ch.total_internal = se_tir_ff;

endmodule

/* dv/dielectric_scatter_direction_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for dielectric_scatter_direction_top: random and directed ray hits,
// fixed-point refraction/reflection prediction and in-order result checking.
// Depends on dsd_pkg, dsd_req_if, dsd_rsp_if and the top level.
module dielectric_scatter_direction_top_tb;
   import dsd_pkg::*;

   typedef struct {
      logic signed [DIR_W-1:0] dx, dy, dz, nx, ny, nz;
      logic back;
      logic [RND_W-1:0] rnd;
   } ray_hit_t;

   typedef struct {
      logic signed [DIR_W-1:0] ox, oy, oz;
      logic [WGT_W-1:0] wr, wg, wb;
      logic refl, tir;
   } scatter_t;

   typedef struct {
      logic [IDX_W-1:0] index;
      logic [ALB_W-1:0] red, green, blue;
   } material_t;

   localparam int STALL_LIMIT = 5000;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   dsd_req_if req_ch();
   dsd_rsp_if rsp_ch();

   dielectric_scatter_direction_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   ray_hit_t pending_hits[$];
   scatter_t expected_scatters[$];
   longint mat_index;
   longint mat_albedo[3];
   int error_count = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int quiet_cycles = 0;
   bit calm = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint root_floor(longint v);
      longint res, bits;
      res = 0;
      bits = 64'sd1 <<< 62;
      while (bits > v) bits = bits >>> 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v = v - (res + bits);
            res = (res >>> 1) + bits;
         end else begin
            res = res >>> 1;
         end
         bits = bits >>> 2;
      end
      return res;
   endfunction

   function automatic longint clamp_dir(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic scatter_t predict_scatter(ray_hit_t h);
      longint one, d[3], n[3], o[3], perp[3];
      longint dot, c, s2, len2, diff, t, wd, aw, w;
      longint eta, num, den, q, r0, m, m2, m4, m5, refl, par;
      bit tir, reflect;
      scatter_t r;
      one = 64'sd1 <<< DIR_FRAC_BITS;
      d[0] = h.dx; d[1] = h.dy; d[2] = h.dz;
      n[0] = h.nx; n[1] = h.ny; n[2] = h.nz;
      if (!h.back) eta = mat_index;
      else if (mat_index == 0) eta = 32767;
      else begin
         eta = ((64'sd1 <<< 24) + mat_index / 2) / mat_index;
         if (eta > 32767) eta = 32767;
      end
      dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
      c = round_shift(-dot, DIR_FRAC_BITS);
      if (c > one) c = one;
      if (c < -one) c = -one;
      s2 = one - round_shift(c * c, DIR_FRAC_BITS);
      tir = eta * eta * s2 > (64'sd1 <<< (2 * IDX_FRAC + DIR_FRAC_BITS));
      num = (eta > 4096) ? eta - 4096 : 4096 - eta;
      den = 4096 + eta;
      q = ((num <<< 16) + den / 2) / den;
      r0 = (q * q + 32768) >>> 16;
      m = 65536 - ((c < 0 ? 64'sd0 : c) <<< (16 - DIR_FRAC_BITS));
      m2 = (m * m + 32768) >>> 16;
      m4 = (m2 * m2 + 32768) >>> 16;
      m5 = (m4 * m + 32768) >>> 16;
      refl = r0 + (((65536 - r0) * m5 + 32768) >>> 16);
      reflect = tir || (refl > h.rnd);
      if (reflect) begin
         for (int i = 0; i < 3; i++)
            o[i] = clamp_dir(d[i] - round_shift(2 * dot * n[i], 2 * DIR_FRAC_BITS));
      end else begin
         len2 = 0;
         for (int i = 0; i < 3; i++) begin
            t = d[i] + round_shift(c * n[i], DIR_FRAC_BITS);
            perp[i] = round_shift(t * eta, IDX_FRAC);
            len2 += perp[i] * perp[i];
         end
         diff = one * one - len2;
         par = root_floor(diff < 0 ? -diff : diff);
         for (int i = 0; i < 3; i++)
            o[i] = clamp_dir(perp[i] - round_shift(par * n[i], DIR_FRAC_BITS));
      end
      wd = n[0] * o[0] + n[1] * o[1] + n[2] * o[2];
      aw = wd < 0 ? -wd : wd;
      r.ox = o[0]; r.oy = o[1]; r.oz = o[2];
      for (int i = 0; i < 3; i++) begin
         w = round_shift(2 * aw * mat_albedo[i], 2 * DIR_FRAC_BITS);
         if (w > WGT_MAX) w = WGT_MAX;
         if (i == 0) r.wr = w;
         else if (i == 1) r.wg = w;
         else r.wb = w;
      end
      r.refl = reflect;
      r.tir = tir;
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Driver.
   always @(posedge clock) begin
      ray_hit_t h;
      bit next_valid;
      next_valid = req_ch.valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            h.dx = req_ch.in_dir_x; h.dy = req_ch.in_dir_y; h.dz = req_ch.in_dir_z;
            h.nx = req_ch.normal_x; h.ny = req_ch.normal_y; h.nz = req_ch.normal_z;
            h.back = req_ch.back_face;
            h.rnd = req_ch.random_value;
            expected_scatters.push_back(predict_scatter(h));
            next_valid = 1'b0;
            send_gap = pick_gap();
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_hits.size() > 0) begin
               h = pending_hits.pop_front();
               next_valid = 1'b1;
               req_ch.in_dir_x <= h.dx; req_ch.in_dir_y <= h.dy; req_ch.in_dir_z <= h.dz;
               req_ch.normal_x <= h.nx; req_ch.normal_y <= h.ny; req_ch.normal_z <= h.nz;
               req_ch.back_face <= h.back;
               req_ch.random_value <= h.rnd;
            end
         end
      end
      req_ch.valid <= next_valid;
   end

   // Monitor and receiver stalls.
   always @(posedge clock) begin
      scatter_t e;
      bit next_ready;
      next_ready = 1'b1;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_scatters.size() == 0) begin
               $display("unexpected result item");
               error_count++;
            end else begin
               e = expected_scatters.pop_front();
               if (rsp_ch.out_dir_x !== e.ox) report("out_dir_x", rsp_ch.out_dir_x, e.ox);
               if (rsp_ch.out_dir_y !== e.oy) report("out_dir_y", rsp_ch.out_dir_y, e.oy);
               if (rsp_ch.out_dir_z !== e.oz) report("out_dir_z", rsp_ch.out_dir_z, e.oz);
               if (rsp_ch.weight_red !== e.wr) report("weight_red", rsp_ch.weight_red, e.wr);
               if (rsp_ch.weight_green !== e.wg)
                  report("weight_green", rsp_ch.weight_green, e.wg);
               if (rsp_ch.weight_blue !== e.wb) report("weight_blue", rsp_ch.weight_blue, e.wb);
               if (rsp_ch.was_reflected !== e.refl)
                  report("was_reflected", rsp_ch.was_reflected, e.refl);
               if (rsp_ch.total_internal !== e.tir)
                  report("total_internal", rsp_ch.total_internal, e.tir);
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            next_ready = 1'b0;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            recv_gap = pick_gap();
         end
      end
      rsp_ch.ready <= next_ready;
   end

   // Watchdog.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("dielectric_scatter_direction_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(csr_reg_type idx, longint value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      if (idx == CSR_REFRACTION_INDEX) mat_index = value & 16'h7FFF;
      else mat_albedo[idx - 1] = value & 16'hFFFF;
   endtask

   task automatic set_material(material_t mat);
      write_reg(CSR_REFRACTION_INDEX, mat.index);
      write_reg(CSR_ALBEDO_RED, mat.red);
      write_reg(CSR_ALBEDO_GREEN, mat.green);
      write_reg(CSR_ALBEDO_BLUE, mat.blue);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain();
      while (pending_hits.size() > 0 || req_ch.valid || expected_scatters.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic longint to_fixed(real v);
      return $rtoi(v >= 0.0 ? v + 0.5 : v - 0.5);
   endfunction

   task automatic unit_vector(output longint x, output longint y, output longint z);
      real a, b, c, len;
      do begin
         a = ($urandom_range(0, 20000) - 10000) / 10000.0;
         b = ($urandom_range(0, 20000) - 10000) / 10000.0;
         c = ($urandom_range(0, 20000) - 10000) / 10000.0;
         len = $sqrt(a * a + b * b + c * c);
      end while (len < 0.05 || len > 1.0);
      x = to_fixed(a * 16384.0 / len);
      y = to_fixed(b * 16384.0 / len);
      z = to_fixed(c * 16384.0 / len);
   endtask

   task automatic add_hit(longint dx, longint dy, longint dz, longint nx, longint ny,
         longint nz, bit back, longint rnd);
      ray_hit_t h;
      h.dx = dx; h.dy = dy; h.dz = dz;
      h.nx = nx; h.ny = ny; h.nz = nz;
      h.back = back;
      h.rnd = rnd;
      pending_hits.push_back(h);
   endtask

   task automatic add_random_hits(int count);
      longint dx, dy, dz, nx, ny, nz;
      int p;
      for (int k = 0; k < count; k++) begin
         p = $urandom_range(0, 99);
         if (p < 88) begin
            unit_vector(dx, dy, dz);
            unit_vector(nx, ny, nz);
            if ((dx * nx + dy * ny + dz * nz > 0) == ($urandom_range(0, 99) < 85)) begin
               nx = -nx; ny = -ny; nz = -nz;
            end
            add_hit(dx, dy, dz, nx, ny, nz, $urandom_range(0, 1), $urandom_range(0, 65535));
         end else begin
            add_hit(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), $urandom_range(0, 1), $urandom_range(0, 65535));
         end
      end
   endtask

   initial begin
      material_t mats[8];
      mats[0] = '{IDX_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      mats[1] = '{15'd4096, 16'd0, 16'd32768, 16'hFFFF};
      mats[2] = '{15'd32767, 16'hFFFF, 16'd1, 16'd40000};
      mats[3] = '{15'd0, 16'd12345, 16'hFFFF, 16'd0};
      mats[4] = '{15'd100, 16'd65534, 16'd777, 16'd50000};
      mats[5] = '{15'd4095, 16'd30000, 16'd60000, 16'd5};
      mats[6] = '{15'($urandom_range(4096, 32767)), 16'($urandom), 16'($urandom),
         16'($urandom)};
      mats[7] = '{15'($urandom_range(4096, 12000)), 16'($urandom), 16'($urandom),
         16'($urandom)};

      mat_index = IDX_RESET;
      for (int i = 0; i < 3; i++) mat_albedo[i] = ALB_RESET;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.in_dir_x = '0; req_ch.in_dir_y = '0; req_ch.in_dir_z = '0;
      req_ch.normal_x = '0; req_ch.normal_y = '0; req_ch.normal_z = '0;
      req_ch.back_face = 1'b0;
      req_ch.random_value = '0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Items at the reset values, before any register write.
      add_hit(0, 0, -16384, 0, 0, 16384, 0, 0);
      add_hit(0, 0, -16384, 0, 0, 16384, 1, 65535);
      add_hit(16384, 0, 0, 0, 0, 16384, 0, 0);
      add_hit(16384, 0, 0, 0, 0, 16384, 1, 65535);
      add_hit(16000, 0, -3500, 0, 0, 16384, 0, 65535);
      add_hit(16000, 0, -3500, 0, 0, 16384, 1, 65535);
      add_hit(0, 0, 16384, 0, 0, 16384, 0, 65535);
      add_hit(0, 0, 16384, 0, 0, 16384, 1, 0);
      add_hit(-16384, -16384, -16384, 16384, 16384, 16384, 0, 65535);
      add_hit(16384, 16384, 16384, 16384, 16384, 16384, 1, 0);
      add_hit(-32768, -32768, -32768, 32767, 32767, 32767, 0, 32768);
      add_hit(-32768, -32768, -32768, -32768, -32768, -32768, 1, 1);
      add_hit(32767, -32768, 32767, -32768, 32767, -32768, 0, 65535);
      add_hit(0, 0, 0, 0, 0, 0, 0, 0);
      add_hit(0, 0, 0, 0, 0, 0, 1, 65535);
      add_hit(11585, 0, -11585, 0, 0, 16384, 0, 3000);
      add_hit(11585, 0, -11585, 0, 0, 16384, 1, 3000);
      add_hit(-16384, 0, 0, 16384, 0, 0, 1, 65535);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         calm = (ph % 3 == 2);
         set_material(mats[ph]);
         add_hit(0, 0, -16384, 0, 0, 16384, 0, 65535);
         add_hit(16000, 0, -3500, 0, 0, 16384, 0, 65535);
         add_hit(16000, 0, -3500, 0, 0, 16384, 1, 65535);
         add_random_hits(90);
         if (ph == 4) begin
            // Hold the sender until every outstanding result has come back.
            while (pending_hits.size() > 0 || req_ch.valid) @(posedge clock);
            while (expected_scatters.size() > 0) @(posedge clock);
         end
         add_random_hits(90);
         drain();
      end

      if (error_count == 0) begin
         $display("dielectric_scatter_direction_top verification clean");
      end else begin
         $display("dielectric_scatter_direction_top verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/dsd_pkg.sv
rtl/dsd_req_if.sv
rtl/dsd_rsp_if.sv
rtl/dielectric_scatter_direction_top.sv
dv/dielectric_scatter_direction_top_tb.sv
